/* src/hpoc_pkg.sv */
// package for the h264 picture order count core
// holds widths, register indexes, sequencer states and small helpers; no dependencies
package hpoc_pkg;

  localparam int CYCLE_DEPTH = 256;
  localparam int IDX_W = $clog2(CYCLE_DEPTH);
  localparam int LEN_W = IDX_W + 1;

  // configuration register indexes
  localparam logic [2:0] REG_POC_TYPE   = 3'd0;
  localparam logic [2:0] REG_LOG2_LSB   = 3'd1;
  localparam logic [2:0] REG_LOG2_FN    = 3'd2;
  localparam logic [2:0] REG_CYCLE_LEN  = 3'd3;
  localparam logic [2:0] REG_NONREF_OFF = 3'd4;
  localparam logic [2:0] REG_T2B_OFF    = 3'd5;

  // poc methods
  localparam logic [1:0] POC_TYPE0     = 2'd0;
  localparam logic [1:0] POC_TYPE1     = 2'd1;
  localparam logic [1:0] POC_TYPE2     = 2'd2;
  localparam logic [1:0] POC_TYPE_NONE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV,
    ST_MUL,
    ST_PART_RD,
    ST_PART_ACC,
    ST_FINISH,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  poc_type;
    logic [4:0]  log2_max_poc_lsb;
    logic [4:0]  log2_max_frame_num;
    logic [7:0]  cycle_length;
    logic [31:0] non_ref_offset;
    logic [31:0] top_to_bottom_offset;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic        is_idr;
    logic        is_reference;
    logic        prev_had_mmco5;
    logic        prev_was_bottom;
    logic        field_pic;
    logic        bottom_field;
    logic [15:0] poc_lsb;
    logic [15:0] frame_number;
    logic [31:0] delta_bottom;
    logic [31:0] delta_first;
    logic [31:0] delta_second;
  } req_t;

  typedef struct packed {
    logic [31:0] current_poc;
    logic [31:0] top_poc;
    logic [31:0] bottom_poc;
    logic [31:0] frame_order;
  } res_t;

  // table port between sequencer and offset memory
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic [IDX_W-1:0] rd_addr;
  } tbl_ctl_t;

  function automatic logic [4:0] clamp_log2(input logic [4:0] v);
    if (v < 5'd4) return 5'd4;
    if (v > 5'd16) return 5'd16;
    return v;
  endfunction

  function automatic logic slt32(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

/* src/hpoc_if.sv */
// valid/ready channel interface used by the h264 picture order count core
// payload type is chosen per instance; no other dependencies
interface hpoc_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/hpoc_table.sv */
// reference frame offset table, one write and one registered read port
// uses hpoc_pkg
module hpoc_table
  import hpoc_pkg::*;
(
  input  logic        clk,
  input  tbl_ctl_t    ctl,
  output logic [31:0] rd_data
);
  logic [31:0] mem [CYCLE_DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data <= mem[ctl.rd_addr];
  end
endmodule

/* src/hpoc_divider.sv */
// restoring divider, one quotient bit per cycle, 32-bit dividend by 9-bit divisor
// uses hpoc_pkg
module hpoc_divider
  import hpoc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [LEN_W-1:0] remainder
);
  logic [5:0]     count;
  logic           busy;
  logic [LEN_W:0] trial;

  assign trial = {remainder, quotient[31]} - {1'b0, divisor};

  // one shift-subtract step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        count     <= 6'd32;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (!trial[LEN_W]) begin
          remainder <= trial[LEN_W-1:0];
          quotient  <= {quotient[30:0], 1'b1};
        end else begin
          remainder <= {remainder[LEN_W-2:0], quotient[31]};
          quotient  <= {quotient[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* src/h264_picture_order_count_core.sv */
// top level of the h264 picture order count core
// uses hpoc_pkg, hpoc_if, hpoc_table and hpoc_divider
//
// Usage: one request channel (in) and one result channel (out), both valid/ready.
// A request is a slice item or a table write; every request gives one result.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block does not enforce. A table write
// or type 0/2 slice goes from idle to the finish and output states. A type 1
// slice reads the table one entry at a time for the cycle sum over the cycle
// length, then runs the divider, a multiply step and the partial sum over
// pos+1 entries. One request is in flight at a time; in is ready only in
// the idle state.
// The result sits in an output register until taken; a stalled receiver
// holds the block in its output state and blocks new requests.
// Reset clears configuration to its defaults and all previous-picture state.
// The offset table holds no reset value; entries read before written are
// undefined.
module h264_picture_order_count_core
  import hpoc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  hpoc_if.sink        in,
  hpoc_if.source      out
);
  cfg_t cfg;
  seq_state_t state, state_next;
  req_t req;
  res_t res;

  logic [15:0] previous_lsb, previous_frame_number;
  logic [31:0] previous_msb, previous_frame_offset;
  logic [31:0] stored_top_poc, stored_bottom_poc, stored_frame_poc;

  tbl_ctl_t    tbl;
  logic [31:0] tbl_data;
  logic [IDX_W-1:0] idx;
  logic [31:0] cycle_sum, expect_acc, absn, cnt;
  logic [IDX_W-1:0] pos;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic [LEN_W-1:0] div_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{poc_type: POC_TYPE0, log2_max_poc_lsb: 5'd4, log2_max_frame_num: 5'd4,
               cycle_length: 8'd0, non_ref_offset: 32'd0, top_to_bottom_offset: 32'd0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POC_TYPE:   cfg.poc_type <= cfg_data[1:0];
        REG_LOG2_LSB:   cfg.log2_max_poc_lsb <= cfg_data[4:0];
        REG_LOG2_FN:    cfg.log2_max_frame_num <= cfg_data[4:0];
        REG_CYCLE_LEN:  cfg.cycle_length <= cfg_data[7:0];
        REG_NONREF_OFF: cfg.non_ref_offset <= cfg_data;
        REG_T2B_OFF:    cfg.top_to_bottom_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived values from the held request
  logic [LEN_W-1:0] len;
  logic [31:0] maxfn, maxl, half, fn, lsb, off, pfn, poff;
  logic [31:0] plsb, pmsb, msb, val0, absn_init, t2_val;
  always_comb begin
    len   = LEN_W'(cfg.cycle_length);
    maxfn = 32'd1 << clamp_log2(cfg.log2_max_frame_num);
    maxl  = 32'd1 << clamp_log2(cfg.log2_max_poc_lsb);
    half  = maxl >> 1;
    fn    = {16'd0, req.frame_number} & (maxfn - 32'd1);
    lsb   = {16'd0, req.poc_lsb} & (maxl - 32'd1);
    pfn   = {16'd0, previous_frame_number};
    poff  = previous_frame_offset;
    if (req.prev_had_mmco5) begin
      pfn  = '0;
      poff = '0;
    end
    if (req.is_idr) off = '0;
    else off = (pfn > fn) ? poff + maxfn : poff;
    plsb = {16'd0, previous_lsb};
    pmsb = previous_msb;
    if (req.is_idr) begin
      plsb = '0;
      pmsb = '0;
    end else if (req.prev_had_mmco5) begin
      pmsb = '0;
      plsb = req.prev_was_bottom ? 32'd0 : {16'd0, stored_top_poc[15:0]};
    end
    if (lsb < plsb && plsb - lsb >= half) msb = pmsb + maxl;
    else if (lsb > plsb && lsb - plsb > half) msb = pmsb - maxl;
    else msb = pmsb;
    val0 = msb + lsb;
    absn_init = (len != '0) ? off + fn : 32'd0;
    if (!req.is_reference && absn_init != 32'd0) absn_init = absn_init - 32'd1;
    if (req.is_idr) t2_val = '0;
    else if (req.is_reference) t2_val = (off + fn) << 1;
    else t2_val = ((off + fn) << 1) - 32'd1;
  end

  logic [31:0] top, bot, cur, expect_fin;
  always_comb begin
    top = stored_top_poc;
    bot = stored_bottom_poc;
    cur = '0;
    expect_fin = expect_acc + (req.is_reference ? 32'd0 : cfg.non_ref_offset);
    case (cfg.poc_type)
      POC_TYPE0: begin
        if (!req.field_pic) begin
          top = val0;
          bot = val0 + req.delta_bottom;
          cur = slt32(bot, top) ? bot : top;
        end else begin
          if (req.bottom_field) bot = val0;
          else top = val0;
          cur = val0;
        end
      end
      POC_TYPE1: begin
        if (!req.field_pic) begin
          top = expect_fin + req.delta_first;
          bot = top + cfg.top_to_bottom_offset + req.delta_second;
          cur = slt32(bot, top) ? bot : top;
        end else if (!req.bottom_field) begin
          top = expect_fin + req.delta_first;
          cur = top;
        end else begin
          bot = expect_fin + cfg.top_to_bottom_offset + req.delta_first;
          cur = bot;
        end
      end
      default: begin
        if (!req.field_pic || req.is_idr) begin
          top = t2_val;
          bot = t2_val;
        end else if (req.bottom_field) bot = t2_val;
        else top = t2_val;
        cur = t2_val;
      end
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // sequencer next state and table control
  always_comb begin
    state_next  = state;
    in.ready    = 1'b0;
    out.valid   = 1'b0;
    div_start   = 1'b0;
    tbl.wr_en   = 1'b0;
    tbl.wr_addr = in.payload.frame_number[IDX_W-1:0];
    tbl.wr_data = in.payload.delta_first;
    tbl.rd_addr = idx;
    case (state)
      ST_IDLE: begin
        in.ready = 1'b1;
        if (in.valid) begin
          tbl.wr_en = in.payload.req_type && (in.payload.frame_number < 16'(CYCLE_DEPTH));
          if (in.payload.req_type || cfg.poc_type != POC_TYPE1) state_next = ST_FINISH;
          else if (len == '0) state_next = ST_FINISH;
          else state_next = ST_SUM_RD;
        end
      end
      ST_SUM_RD:  state_next = ST_SUM_ACC;
      ST_SUM_ACC: begin
        if (idx == IDX_W'(len - LEN_W'(1))) begin
          if (absn == '0) state_next = ST_FINISH;
          else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end else state_next = ST_SUM_RD;
      end
      ST_DIV:      if (div_done) state_next = ST_MUL;
      ST_MUL:      state_next = ST_PART_RD;
      ST_PART_RD:  state_next = ST_PART_ACC;
      ST_PART_ACC: state_next = (idx == pos) ? ST_FINISH : ST_PART_RD;
      ST_FINISH:   state_next = ST_OUT;
      ST_OUT: begin
        out.valid = 1'b1;
        if (out.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out.payload = res;

  hpoc_table u_table (.clk(clk), .ctl(tbl), .rd_data(tbl_data));

  hpoc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(absn - 32'd1),
    .divisor(len), .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  // datapath and previous-picture state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_lsb          <= '0;
      previous_msb          <= '0;
      previous_frame_number <= '0;
      previous_frame_offset <= '0;
      stored_top_poc        <= '0;
      stored_bottom_poc     <= '0;
      stored_frame_poc      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in.valid) begin
            req        <= in.payload;
            idx        <= '0;
            cycle_sum  <= '0;
            expect_acc <= '0;
          end
        end
        ST_SUM_RD: begin
          if (idx == '0) absn <= absn_init;
        end
        ST_SUM_ACC: begin
          cycle_sum <= cycle_sum + tbl_data;
          idx       <= idx + IDX_W'(1);
        end
        ST_DIV: begin
          cnt <= div_q;
          pos <= div_r[IDX_W-1:0];
        end
        ST_MUL: begin
          expect_acc <= cnt * cycle_sum;
          idx        <= '0;
        end
        ST_PART_ACC: begin
          expect_acc <= expect_acc + tbl_data;
          idx        <= idx + IDX_W'(1);
        end
        ST_FINISH: begin
          if (!req.req_type && cfg.poc_type != POC_TYPE_NONE) begin
            res <= '{current_poc: cur, top_poc: top, bottom_poc: bot, frame_order: cur};
            stored_top_poc    <= top;
            stored_bottom_poc <= bot;
            stored_frame_poc  <= cur;
            if (cfg.poc_type == POC_TYPE0) begin
              if (req.is_reference) begin
                previous_lsb <= lsb[15:0];
                previous_msb <= msb;
              end
            end else begin
              previous_frame_number <= fn[15:0];
              previous_frame_offset <= off;
            end
          end else begin
            res <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // a result is offered only from the output state
  assert property (@(posedge clk) disable iff (rst) out.valid |-> state == ST_OUT)
    else $error("result offered outside output state");
  // no request taken while one is in flight
  assert property (@(posedge clk) disable iff (rst) (state != ST_IDLE) |-> !in.ready)
    else $error("ready while busy");
  // divider starts only from the sum loop
  assert property (@(posedge clk) disable iff (rst) div_start |-> state == ST_SUM_ACC)
    else $error("divider started outside sum loop");
  // a taken result returns to idle
  assert property (@(posedge clk) disable iff (rst) (out.valid && out.ready) |=> state == ST_IDLE)
    else $error("no return to idle after transfer");
endmodule
